// ===== sv/assert_macros.svh =====
// Assertion macros for the RTL, included by the reach-count block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check, disabled while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that holds at every clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/rwbc_pkg.sv =====
// Package: widths, codes and state type of the reach-count block.
package rwbc_pkg;

	localparam int MAX_TOWNS_DEF = 64;
	localparam int TOWN_W        = 7;
	localparam int BUDGET_W      = 19;
	localparam int WEIGHT_W      = 14;
	localparam int DIST_W        = 20;
	localparam int COUNT_W       = 7;
	localparam int ACTION_W      = 2;
	localparam int CFG_IDX_W     = 1;

	localparam logic [DIST_W-1:0]  DIST_MAX  = {DIST_W{1'b1}};
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	typedef enum logic [ACTION_W-1:0] {
		ACT_LOAD  = 2'd0,
		ACT_RUN   = 2'd1,
		ACT_CLEAR = 2'd2
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TOWN_COUNT  = 1'b0,
		CFG_TIME_BUDGET = 1'b1
	} cfg_idx_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_LD_RD,
		S_LD_WR1,
		S_LD_WR2,
		S_RUN_INIT,
		S_PICK,
		S_PICK_END,
		S_RELAX,
		S_RELAX_END,
		S_COUNT,
		S_COUNT_END,
		S_DONE
	} state_t;

endpackage

// ===== sv/rwbc_ram.sv =====
// Simple dual-port synchronous RAM, one write and one registered read per cycle.
module rwbc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/reachable_within_budget_count.sv =====
// Load: each edge goes through transfer, read, compare/write and write back.
// Clear: every matrix entry is swept to zero, one matrix entry swept per cycle.
// Run: from transfer to result for n towns, up to n rounds of a distance scan plus a
// matrix row scan; fewer rounds when towns stay unreached.
// Reset: a clearing pass over all MAX_TOWNS*MAX_TOWNS matrix entries runs, no input taken.
// Loads and clears proceed while an earlier result still waits for transfer.
module reachable_within_budget_count #(
	parameter int MAX_TOWNS = rwbc_pkg::MAX_TOWNS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [rwbc_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [rwbc_pkg::BUDGET_W-1:0]  wr_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [rwbc_pkg::ACTION_W-1:0]  action,
	input  logic [rwbc_pkg::TOWN_W-1:0]    end_a,
	input  logic [rwbc_pkg::TOWN_W-1:0]    end_b,
	input  logic [rwbc_pkg::WEIGHT_W-1:0]  travel_time,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [rwbc_pkg::COUNT_W-1:0]   reach_count
);
	import rwbc_pkg::*;

	`include "assert_macros.svh"

	localparam int TW         = $clog2(MAX_TOWNS);
	localparam int CW         = $clog2(MAX_TOWNS + 1);
	localparam int CNT_W      = (CW > COUNT_W) ? CW : COUNT_W;
	localparam int EDGE_DEPTH = MAX_TOWNS * MAX_TOWNS;
	localparam int EAW        = $clog2(EDGE_DEPTH);
	localparam int EW         = WEIGHT_W + 1;

	state_t state_q, state_d;

	// configuration registers
	logic [TOWN_W-1:0]   town_count_q;
	logic [BUDGET_W-1:0] time_budget_q;

	// load operands
	logic [TW-1:0]       ia_q, ib_q;
	logic [WEIGHT_W-1:0] w_q;

	// run control
	logic [TW-1:0]        last_q;
	logic [TW-1:0]        scan_q;
	logic [TW-1:0]        pick_q;
	logic [DIST_W-1:0]    pick_dist_q;
	logic                 found_q;
	logic [MAX_TOWNS-1:0] reached_q;
	logic [MAX_TOWNS-1:0] done_q;
	logic [CNT_W-1:0]     count_q;
	logic [EAW-1:0]       sweep_q;
	logic                 vld_s1;
	logic [TW-1:0]        idx_s1;

	// output register
	logic               out_valid_q;
	logic [COUNT_W-1:0] reach_count_q;

	// memory ports
	logic              edge_we;
	logic [EAW-1:0]    edge_waddr, edge_raddr;
	logic [EW-1:0]     edge_wdata, edge_rdata;
	logic              dist_we;
	logic [TW-1:0]     dist_waddr, dist_raddr;
	logic [DIST_W-1:0] dist_wdata, dist_rdata;

	logic in_xfer, out_free, issue, scan_last, load_ok;
	logic [EAW-1:0] addr_ab, addr_ba, addr_row;
	logic [TW-1:0]  last_d;

	rwbc_ram #(.WIDTH(EW), .DEPTH(EDGE_DEPTH), .AW(EAW)) u_edge_ram (
		.clk   (clk),
		.we    (edge_we),
		.waddr (edge_waddr),
		.wdata (edge_wdata),
		.raddr (edge_raddr),
		.rdata (edge_rdata)
	);

	rwbc_ram #(.WIDTH(DIST_W), .DEPTH(MAX_TOWNS), .AW(TW)) u_dist_ram (
		.clk   (clk),
		.we    (dist_we),
		.waddr (dist_waddr),
		.wdata (dist_wdata),
		.raddr (dist_raddr),
		.rdata (dist_rdata)
	);

	assign in_xfer   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign scan_last = (scan_q == last_q);
	assign load_ok   = (end_a != '0) && (32'(end_a) <= 32'(MAX_TOWNS)) &&
		(end_b != '0) && (32'(end_b) <= 32'(MAX_TOWNS));

	// matrix addresses
	assign addr_ab  = EAW'(32'(ia_q) * MAX_TOWNS + 32'(ib_q));
	assign addr_ba  = EAW'(32'(ib_q) * MAX_TOWNS + 32'(ia_q));
	assign addr_row = EAW'(32'(pick_q) * MAX_TOWNS + 32'(scan_q));

	// clamp the town count to 1..MAX_TOWNS, kept as the last index
	always_comb begin
		if (town_count_q == '0) begin
			last_d = '0;
		end else if (32'(town_count_q) > 32'(MAX_TOWNS)) begin
			last_d = TW'(MAX_TOWNS - 1);
		end else begin
			last_d = TW'(town_count_q - 1'b1);
		end
	end

	// load: keep the smaller weight
	logic ld_better;
	assign ld_better = !edge_rdata[WEIGHT_W] || (w_q < edge_rdata[WEIGHT_W-1:0]);

	// minimum search over reached, unfinished towns
	logic              pick_better, found_any;
	assign pick_better = vld_s1 && reached_q[idx_s1] && !done_q[idx_s1] &&
		(!found_q || (dist_rdata < pick_dist_q));
	assign found_any = found_q || pick_better;

	// relaxation through the picked town, saturating
	logic [DIST_W:0]   relax_sum;
	logic [DIST_W-1:0] relax_cand;
	logic              relax_upd;
	assign relax_sum  = {1'b0, pick_dist_q} + (DIST_W+1)'(edge_rdata[WEIGHT_W-1:0]);
	assign relax_cand = relax_sum[DIST_W] ? DIST_MAX : relax_sum[DIST_W-1:0];
	assign relax_upd  = vld_s1 && edge_rdata[WEIGHT_W] && !done_q[idx_s1] &&
		(!reached_q[idx_s1] || (relax_cand < dist_rdata));

	// final count
	logic count_hit;
	assign count_hit = vld_s1 && reached_q[idx_s1] &&
		(dist_rdata <= DIST_W'(time_budget_q));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (sweep_q == EAW'(EDGE_DEPTH - 1)) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_xfer) begin
					case (action)
						ACT_LOAD:  state_d = load_ok ? S_LD_RD : S_IDLE;
						ACT_RUN:   state_d = S_RUN_INIT;
						ACT_CLEAR: state_d = S_CLEAR;
						default:   state_d = S_IDLE;
					endcase
				end
			end
			S_LD_RD:     state_d = S_LD_WR1;
			S_LD_WR1:    state_d = S_LD_WR2;
			S_LD_WR2:    state_d = S_IDLE;
			S_RUN_INIT:  state_d = S_PICK;
			S_PICK:      if (scan_last) state_d = S_PICK_END;
			S_PICK_END:  state_d = found_any ? S_RELAX : S_COUNT;
			S_RELAX:     if (scan_last) state_d = S_RELAX_END;
			S_RELAX_END: state_d = S_PICK;
			S_COUNT:     if (scan_last) state_d = S_COUNT_END;
			S_COUNT_END: state_d = S_DONE;
			S_DONE:      if (out_free) state_d = S_IDLE;
			default:     state_d = S_IDLE;
		endcase
	end

	// memory controls and handshake per state
	always_comb begin
		in_stall   = 1'b1;
		issue      = 1'b0;
		edge_we    = 1'b0;
		edge_waddr = addr_ab;
		edge_wdata = {1'b1, w_q};
		edge_raddr = addr_ab;
		dist_we    = 1'b0;
		dist_waddr = idx_s1;
		dist_wdata = relax_cand;
		dist_raddr = scan_q;
		case (state_q)
			S_CLEAR: begin
				edge_we    = 1'b1;
				edge_waddr = sweep_q;
				edge_wdata = '0;
			end
			S_IDLE: begin
				in_stall = 1'b0;
			end
			S_LD_WR1: begin
				edge_we    = ld_better;
				edge_raddr = addr_ba;
			end
			S_LD_WR2: begin
				edge_we    = ld_better;
				edge_waddr = addr_ba;
			end
			S_RUN_INIT: begin
				dist_we    = 1'b1;
				dist_waddr = '0;
				dist_wdata = '0;
			end
			S_PICK, S_COUNT: begin
				issue = 1'b1;
			end
			S_RELAX: begin
				issue      = 1'b1;
				edge_raddr = addr_row;
				dist_we    = relax_upd;
			end
			S_RELAX_END: begin
				dist_we = relax_upd;
			end
			default: begin
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			town_count_q  <= TOWN_W'(1);
			time_budget_q <= '0;
		end else if (wr_en) begin
			case (cfg_idx_t'(wr_index))
				CFG_TOWN_COUNT:  town_count_q  <= wr_data[TOWN_W-1:0];
				CFG_TIME_BUDGET: time_budget_q <= wr_data;
				default: begin
				end
			endcase
		end
	end

	// clearing sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
		end else if (state_q == S_CLEAR) begin
			sweep_q <= sweep_q + 1'b1;
		end else begin
			sweep_q <= '0;
		end
	end

	// read pipeline tag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			idx_s1 <= '0;
		end else begin
			vld_s1 <= issue;
			idx_s1 <= scan_q;
		end
	end

	// load operands
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_xfer) begin
			ia_q <= TW'(end_a - 1'b1);
			ib_q <= TW'(end_b - 1'b1);
			w_q  <= travel_time;
		end
	end

	// run sequencing: scan index, pick, reached and finished flags, count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q      <= '0;
			scan_q      <= '0;
			pick_q      <= '0;
			pick_dist_q <= '0;
			found_q     <= 1'b0;
			reached_q   <= '0;
			done_q      <= '0;
			count_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					last_q <= last_d;
				end
				S_RUN_INIT: begin
					reached_q <= MAX_TOWNS'(1);
					done_q    <= '0;
					scan_q    <= '0;
					found_q   <= 1'b0;
					count_q   <= '0;
				end
				S_PICK, S_PICK_END: begin
					if (pick_better) begin
						pick_q      <= idx_s1;
						pick_dist_q <= dist_rdata;
						found_q     <= 1'b1;
					end
					if (state_q == S_PICK_END) begin
						scan_q <= '0;
						if (found_any) begin
							done_q[pick_better ? idx_s1 : pick_q] <= 1'b1;
						end
					end else if (!scan_last) begin
						scan_q <= scan_q + 1'b1;
					end
				end
				S_RELAX, S_RELAX_END: begin
					if (relax_upd) reached_q[idx_s1] <= 1'b1;
					if (state_q == S_RELAX_END) begin
						scan_q  <= '0;
						found_q <= 1'b0;
					end else if (!scan_last) begin
						scan_q <= scan_q + 1'b1;
					end
				end
				S_COUNT, S_COUNT_END: begin
					if (count_hit) count_q <= count_q + 1'b1;
					if (state_q == S_COUNT && !scan_last) scan_q <= scan_q + 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			reach_count_q <= (count_q > CNT_W'(COUNT_MAX)) ? COUNT_MAX
				: count_q[COUNT_W-1:0];
		end
	end

	assign out_valid   = out_valid_q;
	assign reach_count = reach_count_q;

	// checks
	`ASSERT_CLK(a_result_from_run, clk, arst_n, $rose(out_valid) |-> $past(state_q) == S_DONE, "result without a run")
	`ASSERT_CLK(a_dist_no_collide, clk, arst_n, (state_q == S_RELAX && dist_we) |-> dist_waddr != dist_raddr, "distance read and write collide")
	`ASSERT_CLK(a_edge_write_state, clk, arst_n, edge_we |-> (state_q == S_CLEAR || state_q == S_LD_WR1 || state_q == S_LD_WR2), "matrix written outside load or clear")
	`ASSERT_CLK(a_count_bound, clk, arst_n, (state_q == S_COUNT || state_q == S_COUNT_END || state_q == S_DONE) |-> count_q <= CNT_W'(last_q) + 1'b1, "count exceeds towns in use")

endmodule
